/* rtl/sitoa_pkg.sv */
package sitoa_pkg;

  localparam int unsigned NumBits   = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned CharWidth = 6;

  localparam logic [CharWidth-1:0] AsciiZero    = 6'd48;
  localparam logic [CharWidth-1:0] AsciiMinus   = 6'd45;
  localparam logic [CharWidth-1:0] AsciiNewline = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_DIGITS,
    ST_NEWLINE
  } state_t;

endpackage

/* rtl/signed_int_to_decimal_ascii_top.sv */
// Channel   Direction  Signals                   Handshake
// request   in         value[31:0] (signed)      accepted when start && !busy
// result    out        char_code[5:0], last      valid for one cycle while strobe
//
// Every request runs a sign step, a shift-and-add-3 binary-to-BCD loop (one
// magnitude bit per cycle), a scan of the ten BCD digits most significant
// first, and a newline step.
// busy is high from the cycle after acceptance until the newline is shown.
// Reset (rst, synchronous) returns the controller to idle and drops any run.
// Results cannot be stalled; each character appears for exactly one cycle.
module signed_int_to_decimal_ascii_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sitoa_pkg::NumBits-1:0]  value,
  output logic                                  strobe,
  output logic        [sitoa_pkg::CharWidth-1:0] char_code,
  output logic                                  last
);

  sitoa_pkg::state_t state, state_next;

  logic [sitoa_pkg::NumBits-1:0]  mag;
  logic                           neg;
  logic [sitoa_pkg::BcdWidth-1:0] bcd;
  logic [sitoa_pkg::BcdWidth-1:0] bcd_adj;
  logic [4:0]                     bit_cnt;
  logic [3:0]                     dig_cnt;
  logic                           started;
  logic [3:0]                     top_digit;
  logic                           digit_shown;

  assign top_digit = bcd[sitoa_pkg::BcdWidth-1 -: 4];

  // A digit is printed once a nonzero digit has been seen, and the ones
  // digit is always printed so that zero reads as a single '0'.
  assign digit_shown = started || (top_digit != 4'd0) || (dig_cnt == 4'd1);

  // Add-3 correction on every digit that is five or more, ahead of the shift.
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < sitoa_pkg::NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sitoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    strobe     = 1'b0;
    char_code  = sitoa_pkg::AsciiZero;
    last       = 1'b0;
    case (state)
      sitoa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = sitoa_pkg::ST_SIGN;
        end
      end
      sitoa_pkg::ST_SIGN: begin
        strobe     = neg;
        char_code  = sitoa_pkg::AsciiMinus;
        state_next = sitoa_pkg::ST_CONV;
      end
      sitoa_pkg::ST_CONV: begin
        if (bit_cnt == 5'(sitoa_pkg::NumBits - 1)) begin
          state_next = sitoa_pkg::ST_DIGITS;
        end
      end
      sitoa_pkg::ST_DIGITS: begin
        strobe    = digit_shown;
        char_code = sitoa_pkg::AsciiZero + {2'b00, top_digit};
        if (dig_cnt == 4'd1) begin
          state_next = sitoa_pkg::ST_NEWLINE;
        end
      end
      sitoa_pkg::ST_NEWLINE: begin
        strobe     = 1'b1;
        char_code  = sitoa_pkg::AsciiNewline;
        last       = 1'b1;
        state_next = sitoa_pkg::ST_IDLE;
      end
      default: begin
        state_next = sitoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      sitoa_pkg::ST_IDLE: begin
        mag     <= value;
        neg     <= value[sitoa_pkg::NumBits-1];
        bcd     <= '0;
        bit_cnt <= '0;
        dig_cnt <= 4'(sitoa_pkg::NumDigits);
        started <= 1'b0;
      end
      sitoa_pkg::ST_SIGN: begin
        // The magnitude of the most negative value still fits 32 unsigned bits.
        if (neg) begin
          mag <= ~mag + 1'b1;
        end
      end
      sitoa_pkg::ST_CONV: begin
        bcd     <= {bcd_adj[sitoa_pkg::BcdWidth-2:0], mag[sitoa_pkg::NumBits-1]};
        mag     <= {mag[sitoa_pkg::NumBits-2:0], 1'b0};
        bit_cnt <= bit_cnt + 5'd1;
      end
      sitoa_pkg::ST_DIGITS: begin
        bcd     <= {bcd[sitoa_pkg::BcdWidth-5:0], 4'd0};
        dig_cnt <= dig_cnt - 4'd1;
        started <= digit_shown;
      end
      default: begin
      end
    endcase
  end

endmodule
